>>> sv/ubbf_pkg.sv
// Shared constants, codes and controller/datapath interface types for the bridge buffer.
package ubbf_pkg;

    localparam int HOST_DEPTH = 128;
    localparam int HOST_AW = $clog2(HOST_DEPTH);
    localparam int UART_DEPTH = 256;
    localparam int UART_AW = $clog2(UART_DEPTH);
    localparam int IN_PKT_MAX = 64;
    localparam int PKT_CW = $clog2(IN_PKT_MAX + 1);
    localparam int REM_W = (IN_PKT_MAX > 1) ? $clog2(IN_PKT_MAX) : 1;
    localparam int APB_AW = 4;
    localparam int APB_DW = 32;

    localparam logic [HOST_AW-1:0] HOST_FREE_MAX = HOST_AW'(HOST_DEPTH - 1);

    localparam logic [15:0] FLUSH_TICKS_RST = 16'd8000;
    localparam logic [15:0] LED_STEP_RST = 16'd65535;
    localparam logic [7:0] LED_PULSE_RST = 8'd3;

    typedef enum logic [2:0] {
        CMD_HOST = 3'd0,
        CMD_URX  = 3'd1,
        CMD_UTX  = 3'd2,
        CMD_TICK = 3'd3,
        CMD_POLL = 3'd4
    } cmd_code_t;

    typedef enum logic [1:0] {
        KIND_STATUS = 2'd0,
        KIND_UART   = 2'd1,
        KIND_IN     = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        REG_FLUSH_TICKS = 2'd0,
        REG_LED_STEP    = 2'd1,
        REG_LED_PULSE   = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic exec;
        logic load_host;
        logic load_uart;
        logic stream_rd;
    } ctl_cmd_t;

    typedef struct packed {
        logic pop;
        logic send;
        logic more;
    } ctl_sts_t;

endpackage

>>> sv/usb_uart_bridge_buffer_flush.sv
// Top level of the USB/UART bridge buffer with timed IN flush.
//
//   Channel   Ports                          Role
//   s_        s_valid/s_ready + item fields  commands and bytes in
//   m_        m_valid/m_ready + result       result beats out
//   APB       psel..prdata, pready           register writes and reads
//
// A status-only item is executed in the idle state and its beat is presented in the hold state.
// A UART pop passes through a host-load state because of the registered host ring read.
// An IN packet passes through a uart-load state before each byte's beat, set by the registered uart ring read per byte.
// Output stalls hold the current beat; no new item is accepted until the last beat goes.
// Synchronous active-low reset clears pointers, timers and LED counters; no ring clearing pass.
module usb_uart_bridge_buffer_flush (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [2:0]                    s_cmd,
    input  logic [7:0]                    s_data,
    input  logic [6:0]                    s_packet_len,
    input  logic                          s_first_of_packet,
    input  logic                          s_in_ready,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_kind,
    output logic [7:0]                    m_out_byte,
    output logic                          m_last,
    output logic                          m_accepted,
    output logic                          m_rx_led,
    output logic                          m_tx_led,
    output logic [7:0]                    m_uart_ring_count,
    output logic [6:0]                    m_host_ring_free,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ubbf_pkg::APB_AW-1:0]   paddr,
    input  logic [ubbf_pkg::APB_DW-1:0]   pwdata,
    output logic [ubbf_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import ubbf_pkg::*;

    ctl_cmd_t cmd;
    ctl_sts_t sts;

    assign pready = 1'b1;

    ubbf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    ubbf_dp u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_cmd             (s_cmd),
        .s_data            (s_data),
        .s_packet_len      (s_packet_len),
        .s_first_of_packet (s_first_of_packet),
        .s_in_ready        (s_in_ready),
        .cmd               (cmd),
        .sts               (sts),
        .m_kind            (m_kind),
        .m_out_byte        (m_out_byte),
        .m_last            (m_last),
        .m_accepted        (m_accepted),
        .m_rx_led          (m_rx_led),
        .m_tx_led          (m_tx_led),
        .m_uart_ring_count (m_uart_ring_count),
        .m_host_ring_free  (m_host_ring_free),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata)
    );

endmodule

>>> sv/ubbf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module ubbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/ubbf_ctrl.sv
// Controller state machine sequencing item execution and result beats.
module ubbf_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output ubbf_pkg::ctl_cmd_t  cmd,
    input  ubbf_pkg::ctl_sts_t  sts
);
    import ubbf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE    = 4'b0001,
        S_HOST_LD = 4'b0010,
        S_UART_LD = 4'b0100,
        S_HOLD    = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.exec = 1'b1;
                    if (sts.pop) begin
                        state_next = S_HOST_LD;
                    end else if (sts.send) begin
                        state_next = S_UART_LD;
                    end else begin
                        state_next = S_HOLD;
                    end
                end
            end
            S_HOST_LD: begin
                cmd.load_host = 1'b1;
                state_next = S_HOLD;
            end
            S_UART_LD: begin
                cmd.load_uart = 1'b1;
                state_next = S_HOLD;
            end
            S_HOLD: begin
                if (m_ready) begin
                    if (sts.more) begin
                        cmd.stream_rd = 1'b1;
                        state_next = S_UART_LD;
                    end else begin
                        state_next = S_IDLE;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = (state_reg == S_HOLD);

`ifndef NO_ASSERTIONS
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted again before results were delivered");

    a_idle_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !sts.more |=> s_ready)
        else $error("controller did not return to idle after the final beat");
`endif

endmodule

>>> sv/ubbf_dp.sv
// Datapath with both rings, pointers, timers, LED counters, registers and result register.
module ubbf_dp (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [2:0]                    s_cmd,
    input  logic [7:0]                    s_data,
    input  logic [6:0]                    s_packet_len,
    input  logic                          s_first_of_packet,
    input  logic                          s_in_ready,
    input  ubbf_pkg::ctl_cmd_t            cmd,
    output ubbf_pkg::ctl_sts_t            sts,
    output logic [1:0]                    m_kind,
    output logic [7:0]                    m_out_byte,
    output logic                          m_last,
    output logic                          m_accepted,
    output logic                          m_rx_led,
    output logic                          m_tx_led,
    output logic [7:0]                    m_uart_ring_count,
    output logic [6:0]                    m_host_ring_free,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ubbf_pkg::APB_AW-1:0]   paddr,
    input  logic [ubbf_pkg::APB_DW-1:0]   pwdata,
    output logic [ubbf_pkg::APB_DW-1:0]   prdata
);
    import ubbf_pkg::*;

    logic [15:0] flush_ticks_reg, flush_ticks_next;
    logic [15:0] led_step_reg, led_step_next;
    logic [7:0] led_pulse_reg, led_pulse_next;
    logic [HOST_AW-1:0] host_wr_reg, host_wr_next;
    logic [HOST_AW-1:0] host_rd_reg, host_rd_next;
    logic taking_reg, taking_next;
    logic [UART_AW-1:0] uart_wr_reg, uart_wr_next;
    logic [UART_AW-1:0] uart_rd_reg, uart_rd_next;
    logic [UART_AW-1:0] seen_reg, seen_next;
    logic pending_reg, pending_next;
    logic [15:0] flush_timer_reg, flush_timer_next;
    logic [15:0] prescale_reg, prescale_next;
    logic [7:0] tx_left_reg, tx_left_next;
    logic [7:0] rx_left_reg, rx_left_next;
    logic [UART_AW-1:0] send_ptr_reg, send_ptr_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    kind_t kind_reg, kind_next;
    logic [7:0] byte_reg, byte_next;
    logic last_reg, last_next;
    logic acc_reg, acc_next;

    logic [HOST_AW-1:0] host_count;
    logic [HOST_AW-1:0] host_free;
    logic [UART_AW-1:0] uart_count;
    logic plen_ok;
    logic host_take;
    logic send_due;
    logic [PKT_CW-1:0] tx_len;
    logic [15:0] ft_inc;
    logic [15:0] ps_inc;
    logic cfg_wr;
    logic [1:0] cfg_idx;
    logic host_we, host_re, uart_we, uart_re;
    logic [UART_AW-1:0] uart_raddr;
    logic [7:0] host_rdata, uart_rdata;

    assign host_count = host_wr_reg - host_rd_reg;
    assign host_free = HOST_FREE_MAX - host_count;
    assign uart_count = uart_wr_reg - uart_rd_reg;
    assign plen_ok = (s_packet_len != 7'd0) && (HOST_AW'(s_packet_len) <= host_free);
    assign host_take = s_first_of_packet ? plen_ok : (taking_reg && host_free != '0);
    assign send_due = ((uart_count >= UART_AW'(IN_PKT_MAX)) ||
                       (pending_reg && uart_count != '0)) && s_in_ready;
    assign tx_len = (uart_count >= UART_AW'(IN_PKT_MAX)) ? PKT_CW'(IN_PKT_MAX)
                                                         : PKT_CW'(uart_count);
    assign ft_inc = flush_timer_reg + 16'd1;
    assign ps_inc = prescale_reg + 16'd1;

    assign sts.pop = (s_cmd == CMD_UTX) && (host_count != '0);
    assign sts.send = (s_cmd == CMD_POLL) && send_due;
    assign sts.more = (rem_reg != '0);

    assign cfg_wr = psel && penable && pwrite;
    assign cfg_idx = paddr[3:2];

    assign host_we = cmd.exec && (s_cmd == CMD_HOST) && host_take;
    assign host_re = cmd.exec && sts.pop;
    assign uart_we = cmd.exec && (s_cmd == CMD_URX);
    assign uart_re = (cmd.exec && sts.send) || cmd.stream_rd;
    assign uart_raddr = cmd.exec ? uart_rd_reg : send_ptr_reg;

    ubbf_ram #(.WIDTH(8), .DEPTH(HOST_DEPTH)) u_host_ram (
        .aclk  (aclk),
        .we    (host_we),
        .waddr (host_wr_reg),
        .wdata (s_data),
        .re    (host_re),
        .raddr (host_rd_reg),
        .rdata (host_rdata)
    );

    ubbf_ram #(.WIDTH(8), .DEPTH(UART_DEPTH)) u_uart_ram (
        .aclk  (aclk),
        .we    (uart_we),
        .waddr (uart_wr_reg),
        .wdata (s_data),
        .re    (uart_re),
        .raddr (uart_raddr),
        .rdata (uart_rdata)
    );

    always_comb begin
        flush_ticks_next = flush_ticks_reg;
        led_step_next = led_step_reg;
        led_pulse_next = led_pulse_reg;
        host_wr_next = host_wr_reg;
        host_rd_next = host_rd_reg;
        taking_next = taking_reg;
        uart_wr_next = uart_wr_reg;
        uart_rd_next = uart_rd_reg;
        seen_next = seen_reg;
        pending_next = pending_reg;
        flush_timer_next = flush_timer_reg;
        prescale_next = prescale_reg;
        tx_left_next = tx_left_reg;
        rx_left_next = rx_left_reg;
        send_ptr_next = send_ptr_reg;
        rem_next = rem_reg;
        kind_next = kind_reg;
        byte_next = byte_reg;
        last_next = last_reg;
        acc_next = acc_reg;

        if (cfg_wr) begin
            case (cfg_idx)
                REG_FLUSH_TICKS: flush_ticks_next = pwdata[15:0];
                REG_LED_STEP:    led_step_next = pwdata[15:0];
                REG_LED_PULSE:   led_pulse_next = pwdata[7:0];
                default: ;
            endcase
        end

        if (cmd.exec) begin
            kind_next = KIND_STATUS;
            byte_next = 8'd0;
            last_next = 1'b1;
            acc_next = 1'b0;
            case (s_cmd)
                CMD_HOST: begin
                    taking_next = s_first_of_packet ? plen_ok
                                                    : (taking_reg && host_free != '0);
                    acc_next = host_take;
                    if (host_take) begin
                        host_wr_next = host_wr_reg + 1'b1;
                        rx_left_next = led_pulse_reg;
                    end
                end
                CMD_URX: begin
                    uart_wr_next = uart_wr_reg + 1'b1;
                end
                CMD_UTX: begin
                    if (host_count != '0) begin
                        host_rd_next = host_rd_reg + 1'b1;
                    end
                end
                CMD_TICK: begin
                    if (ft_inc >= flush_ticks_reg) begin
                        flush_timer_next = 16'd0;
                        pending_next = 1'b1;
                    end else begin
                        flush_timer_next = ft_inc;
                    end
                    if (ps_inc >= led_step_reg) begin
                        prescale_next = 16'd0;
                        if (tx_left_reg != 8'd0) begin
                            tx_left_next = tx_left_reg - 8'd1;
                        end
                        if (rx_left_reg != 8'd0) begin
                            rx_left_next = rx_left_reg - 8'd1;
                        end
                    end else begin
                        prescale_next = ps_inc;
                    end
                end
                CMD_POLL: begin
                    pending_next = 1'b0;
                    if (host_count != '0) begin
                        rx_left_next = led_pulse_reg;
                    end
                    if (send_due) begin
                        uart_rd_next = uart_rd_reg + UART_AW'(tx_len);
                        send_ptr_next = uart_rd_reg + 1'b1;
                        rem_next = REM_W'(tx_len - 1'b1);
                        seen_next = seen_reg - UART_AW'(tx_len);
                        flush_timer_next = 16'd0;
                        tx_left_next = led_pulse_reg;
                    end else if (seen_reg != uart_count) begin
                        seen_next = uart_count;
                        flush_timer_next = 16'd0;
                        tx_left_next = led_pulse_reg;
                    end
                end
                default: ;
            endcase
        end

        if (cmd.stream_rd) begin
            send_ptr_next = send_ptr_reg + 1'b1;
            rem_next = rem_reg - 1'b1;
        end

        if (cmd.load_host) begin
            kind_next = KIND_UART;
            byte_next = host_rdata;
            last_next = 1'b1;
            acc_next = 1'b0;
        end

        if (cmd.load_uart) begin
            kind_next = KIND_IN;
            byte_next = uart_rdata;
            last_next = (rem_reg == '0);
            acc_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flush_ticks_reg <= FLUSH_TICKS_RST;
            led_step_reg <= LED_STEP_RST;
            led_pulse_reg <= LED_PULSE_RST;
            host_wr_reg <= '0;
            host_rd_reg <= '0;
            taking_reg <= 1'b0;
            uart_wr_reg <= '0;
            uart_rd_reg <= '0;
            seen_reg <= '0;
            pending_reg <= 1'b0;
            flush_timer_reg <= 16'd0;
            prescale_reg <= 16'd0;
            tx_left_reg <= 8'd0;
            rx_left_reg <= 8'd0;
            rem_reg <= '0;
        end else begin
            flush_ticks_reg <= flush_ticks_next;
            led_step_reg <= led_step_next;
            led_pulse_reg <= led_pulse_next;
            host_wr_reg <= host_wr_next;
            host_rd_reg <= host_rd_next;
            taking_reg <= taking_next;
            uart_wr_reg <= uart_wr_next;
            uart_rd_reg <= uart_rd_next;
            seen_reg <= seen_next;
            pending_reg <= pending_next;
            flush_timer_reg <= flush_timer_next;
            prescale_reg <= prescale_next;
            tx_left_reg <= tx_left_next;
            rx_left_reg <= rx_left_next;
            rem_reg <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        send_ptr_reg <= send_ptr_next;
        kind_reg <= kind_next;
        byte_reg <= byte_next;
        last_reg <= last_next;
        acc_reg <= acc_next;
    end

    always_comb begin
        case (cfg_idx)
            REG_FLUSH_TICKS: prdata = APB_DW'(flush_ticks_reg);
            REG_LED_STEP:    prdata = APB_DW'(led_step_reg);
            REG_LED_PULSE:   prdata = APB_DW'(led_pulse_reg);
            default:         prdata = '0;
        endcase
    end

    assign m_kind = kind_reg;
    assign m_out_byte = byte_reg;
    assign m_last = last_reg;
    assign m_accepted = acc_reg;
    assign m_rx_led = (rx_left_reg != 8'd0);
    assign m_tx_led = (tx_left_reg != 8'd0);
    assign m_uart_ring_count = uart_count;
    assign m_host_ring_free = host_free;

`ifndef NO_ASSERTIONS
    a_exec_stream_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.exec && cmd.stream_rd))
        else $error("uart ring read address claimed by execute and stream at once");

    a_host_store_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.exec && (s_cmd == CMD_HOST) && host_take |=> m_host_ring_free != HOST_FREE_MAX)
        else $error("stored host byte left the host ring reported empty");
`endif

endmodule
